/* rtl/core/lrbd_pkg.sv */
// Package for the line-releasing ring buffer: word types, codes and constants.
// Used by every module of the block; depends on nothing.
package lrbd_pkg;

    // Default ring size in bytes
    localparam int RING_BYTES_DEF = 16384;

    // Fixed field widths
    localparam int CUT_W     = 13;
    localparam int USED_W    = 15;
    localparam int DROP_W    = 32;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    // Wide enough for pointer plus offset at the largest ring size
    localparam int WRAP_W = 18;

    localparam logic [CUT_W-1:0] CHUNK_MAX      = 13'd4096;
    localparam logic [CUT_W-1:0] CHUNK_ONE      = 13'd1;
    localparam logic [CUT_W-1:0] CHUNK_RESET    = 13'd3072;
    localparam logic [7:0]       LINE_END_RESET = 8'd10;

    // Command modes
    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_DRAIN = 2'd1;
    localparam logic [1:0] MODE_PULL  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_DROPPED = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_END    = 1'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  data_byte;
        logic [15:0] msg_len;
        logic        msg_first;
        logic        msg_last;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        out_byte;
        logic              run_last;
        logic [CUT_W-1:0]  cut_length;
        logic [DROP_W-1:0] drop_count;
        logic [USED_W-1:0] used_bytes;
    } rsp_word_t;

    // Push path control toward the top level
    typedef struct packed {
        logic wr_en;    // stage one byte into the ring
        logic commit;   // message complete, commit staged bytes
        logic discard;  // byte belongs to a dropped message
    } push_ctl_t;

    // Ring position plus offset, wrapped once; callers keep sum below twice the ring
    function automatic logic [WRAP_W-1:0] ring_wrap(input logic [WRAP_W-1:0] pos,
                                                    input logic [WRAP_W-1:0] delta,
                                                    input logic [WRAP_W-1:0] ring);
        logic [WRAP_W-1:0] sum;
        sum = pos + delta;
        if (sum >= ring)
        begin
            sum = sum - ring;
        end
        return sum;
    endfunction

endpackage

/* rtl/core/lrbd_push.sv */
// Message admission for the ring: space check, drop counting, staging and commit.
// Depends on lrbd_pkg; drives the ring write port of the top level.
module lrbd_push
    import lrbd_pkg::*;
#(
    parameter int RING_BYTES = RING_BYTES_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  fire,
    input  cmd_word_t                             cmd,
    input  logic [$clog2(RING_BYTES+1)-1:0]       used,
    output push_ctl_t                             ctl,
    output logic [$clog2(RING_BYTES)-1:0]         wr_addr,
    output logic [$clog2(RING_BYTES+1)-1:0]       commit_count,
    output logic [DROP_W-1:0]                     drop_count
);

    localparam int PTR_W = $clog2(RING_BYTES);
    localparam int CNT_W = $clog2(RING_BYTES + 1);
    localparam int CMP_W = ((CNT_W > 16) ? CNT_W : 16) + 1;

    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [CNT_W-1:0]  pc_reg, pc_next;
    logic [15:0]       pl_reg, pl_next;
    logic              disc_reg, disc_next;
    logic [DROP_W-1:0] drop_reg, drop_next;

    logic [CMP_W-1:0]  len_x;
    logic [CMP_W-1:0]  ring_x;
    logic [CMP_W-1:0]  free_x;
    logic [WRAP_W-1:0] wr_wrap;
    logic [WRAP_W-1:0] wp_wrap;

    assign len_x  = CMP_W'(cmd.msg_len);
    assign ring_x = CMP_W'(RING_BYTES);
    assign free_x = ring_x - CMP_W'(used);

    // Admission, staging and commit
    always_comb
    begin
        wp_next      = wp_reg;
        pc_next      = pc_reg;
        pl_next      = pl_reg;
        disc_next    = disc_reg;
        drop_next    = drop_reg;
        ctl          = '0;
        commit_count = '0;
        wr_wrap      = ring_wrap(WRAP_W'(wp_reg), WRAP_W'(pc_reg), WRAP_W'(RING_BYTES));
        wp_wrap      = WRAP_W'(wp_reg);
        if (fire)
        begin
            if (cmd.msg_first)
            begin
                // a new message abandons whatever was open
                pc_next   = '0;
                pl_next   = '0;
                disc_next = 1'b0;
                if (cmd.msg_len != 16'd0)
                begin
                    if (len_x > ring_x || len_x > free_x)
                    begin
                        drop_next = drop_reg + 1'b1;
                        disc_next = 1'b1;
                    end
                    else
                    begin
                        pl_next = cmd.msg_len;
                    end
                end
            end
            if (disc_next)
            begin
                ctl.discard = 1'b1;
                if (cmd.msg_last)
                begin
                    disc_next = 1'b0;
                end
            end
            else if (pl_next != 16'd0)
            begin
                if (CMP_W'(pc_next) < CMP_W'(pl_next))
                begin
                    ctl.wr_en = 1'b1;
                    wr_wrap   = ring_wrap(WRAP_W'(wp_reg), WRAP_W'(pc_next),
                                          WRAP_W'(RING_BYTES));
                    pc_next   = pc_next + 1'b1;
                end
                if (cmd.msg_last)
                begin
                    ctl.commit   = 1'b1;
                    commit_count = pc_next;
                    wp_wrap      = ring_wrap(WRAP_W'(wp_reg), WRAP_W'(pc_next),
                                             WRAP_W'(RING_BYTES));
                    wp_next      = wp_wrap[PTR_W-1:0];
                    pc_next      = '0;
                    pl_next      = '0;
                end
            end
        end
    end

    assign wr_addr    = wr_wrap[PTR_W-1:0];
    assign drop_count = drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            pc_reg   <= '0;
            pl_reg   <= '0;
            disc_reg <= 1'b0;
            drop_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            pc_reg   <= pc_next;
            pl_reg   <= pl_next;
            disc_reg <= disc_next;
            drop_reg <= drop_next;
        end
    end

endmodule

/* rtl/core/line_ring_buffer_drain_core.sv */
// Top level of the line-releasing ring buffer: ring memory, drain scan, pull path.
// Depends on lrbd_pkg and lrbd_push.
//
// Push, pull and no-op commands are taken one per cycle while no drain is
// running; each answers with a one-cycle done strobe in the cycle after start
// is taken, and the receiver cannot hold it off. A drain scans its window of
// min(used_bytes, chunk_limit) bytes backward from the far end through the
// single read port of the ring memory, one byte per cycle, and holds busy
// until its result word is out. It stops at the last line end in the window,
// or at the window's near end when there is none; on an empty ring it answers
// in the cycle after it is taken. The ring needs no clearing after reset: only
// committed bytes are read.
module line_ring_buffer_drain_core
    import lrbd_pkg::*;
#(
    parameter int RING_BYTES = RING_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_word_t            cmd,
    output logic                 done,
    output rsp_word_t            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int PTR_W = $clog2(RING_BYTES);
    localparam int CNT_W = $clog2(RING_BYTES + 1);
    localparam int NW    = (CNT_W > CUT_W) ? CNT_W : CUT_W;

    typedef enum logic [1:0] {
        ST_READY = 2'b01,
        ST_SCAN  = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CUT_W-1:0]  chunk_reg;
    logic [7:0]        line_end_reg;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CUT_W-1:0]  rem_reg, rem_next;
    logic [CUT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [CUT_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              done_reg, done_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              res_pull_reg, res_pull_next;
    logic              res_rlast_reg, res_rlast_next;
    logic [CUT_W-1:0]  res_cut_reg, res_cut_next;
    logic [7:0]        rd_q_reg;

    logic [7:0]        ring_mem [RING_BYTES];

    logic              accept;
    logic              push_fire;
    push_ctl_t         push_ctl;
    logic [PTR_W-1:0]  wr_addr;
    logic [CNT_W-1:0]  commit_count;
    logic [DROP_W-1:0] drop_count;

    logic [CUT_W-1:0]  lim_c;
    logic [CUT_W-1:0]  n_c;
    logic              pull_ok;
    logic              match;
    logic [WRAP_W-1:0] scan_wrap;
    logic [WRAP_W-1:0] rp_wrap;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [31:0]       used_wide;

    assign busy      = (state_reg == ST_SCAN);
    assign accept    = start && !busy;
    assign push_fire = accept && (cmd.mode == MODE_PUSH);

    // Message admission and staging
    lrbd_push #(
        .RING_BYTES (RING_BYTES)
    ) u_push (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (push_fire),
        .cmd          (cmd),
        .used         (used_reg),
        .ctl          (push_ctl),
        .wr_addr      (wr_addr),
        .commit_count (commit_count),
        .drop_count   (drop_count)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg    <= CHUNK_RESET;
            line_end_reg <= LINE_END_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHUNK_LIMIT: chunk_reg    <= cfg_data;
                CFG_LINE_END:    line_end_reg <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // Drain window: chunk limit clamped to 1..4096, then to the committed bytes
    always_comb
    begin
        if (chunk_reg == '0)
        begin
            lim_c = CHUNK_ONE;
        end
        else if (chunk_reg > CHUNK_MAX)
        begin
            lim_c = CHUNK_MAX;
        end
        else
        begin
            lim_c = chunk_reg;
        end
        n_c = (NW'(used_reg) < NW'(lim_c)) ? CUT_W'(used_reg) : lim_c;
    end

    assign pull_ok   = (rem_reg != '0) && (used_reg != '0);
    assign match     = (rd_q_reg == line_end_reg);
    assign scan_wrap = ring_wrap(WRAP_W'(rp_reg), WRAP_W'(CUT_W'(scan_idx_reg - 1'b1)),
                                 WRAP_W'(RING_BYTES));
    assign rp_wrap   = ring_wrap(WRAP_W'(rp_reg), WRAP_W'(1), WRAP_W'(RING_BYTES));

    // Command sequencing and drain scan
    always_comb
    begin
        state_next      = state_reg;
        rp_next         = rp_reg;
        used_next       = used_reg;
        rem_next        = rem_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        done_next       = 1'b0;
        res_status_next = STAT_DONE;
        res_pull_next   = 1'b0;
        res_rlast_next  = 1'b0;
        res_cut_next    = '0;
        rd_en           = 1'b0;
        rd_addr         = rp_reg;

        if (push_ctl.commit)
        begin
            used_next = used_reg + commit_count;
        end

        unique case (state_reg)
            ST_READY:
            begin
                if (accept)
                begin
                    case (cmd.mode)
                        MODE_PUSH:
                        begin
                            done_next       = 1'b1;
                            res_status_next = push_ctl.discard ? STAT_DROPPED : STAT_DONE;
                        end
                        MODE_DRAIN:
                        begin
                            if (n_c == '0)
                            begin
                                done_next       = 1'b1;
                                res_status_next = STAT_EMPTY;
                                rem_next        = '0;
                            end
                            else
                            begin
                                state_next     = ST_SCAN;
                                scan_idx_next  = n_c;
                                cmp_valid_next = 1'b0;
                            end
                        end
                        MODE_PULL:
                        begin
                            done_next = 1'b1;
                            if (pull_ok)
                            begin
                                rd_en          = 1'b1;
                                rp_next        = rp_wrap[PTR_W-1:0];
                                used_next      = used_reg - 1'b1;
                                rem_next       = rem_reg - 1'b1;
                                res_pull_next  = 1'b1;
                                res_rlast_next = (rem_reg == CHUNK_ONE);
                            end
                            else
                            begin
                                rem_next        = '0;
                                res_status_next = STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle from the far end of the window
                if (scan_idx_reg != '0)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_wrap[PTR_W-1:0];
                    scan_idx_next  = scan_idx_reg - 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
                // compare the byte read last cycle; stop on a hit or window end
                if (cmp_valid_reg && (match || scan_idx_reg == '0))
                begin
                    state_next      = ST_READY;
                    cmp_valid_next  = 1'b0;
                    done_next       = 1'b1;
                    res_cut_next    = match ? cmp_idx_reg : '0;
                    rem_next        = match ? cmp_idx_reg : '0;
                    res_status_next = match ? STAT_DONE : STAT_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    // Ring memory: one write port for pushes, one registered read port
    always_ff @(posedge clk)
    begin
        if (push_ctl.wr_en)
        begin
            ring_mem[wr_addr] <= cmd.data_byte;
        end
        if (rd_en)
        begin
            rd_q_reg <= ring_mem[rd_addr];
        end
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_READY;
            rp_reg         <= '0;
            used_reg       <= '0;
            rem_reg        <= '0;
            scan_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_idx_reg    <= '0;
            done_reg       <= 1'b0;
            res_status_reg <= STAT_DONE;
            res_pull_reg   <= 1'b0;
            res_rlast_reg  <= 1'b0;
            res_cut_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rp_reg         <= rp_next;
            used_reg       <= used_next;
            rem_reg        <= rem_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            cmp_idx_reg    <= cmp_idx_next;
            done_reg       <= done_next;
            res_status_reg <= res_status_next;
            res_pull_reg   <= res_pull_next;
            res_rlast_reg  <= res_rlast_next;
            res_cut_reg    <= res_cut_next;
        end
    end

    // Result word; counters are read live, they only move on a taken command
    assign used_wide       = 32'(used_reg);
    assign done            = done_reg;
    assign rsp.status      = res_status_reg;
    assign rsp.out_byte    = res_pull_reg ? rd_q_reg : 8'd0;
    assign rsp.run_last    = res_rlast_reg;
    assign rsp.cut_length  = res_cut_reg;
    assign rsp.drop_count  = drop_count;
    assign rsp.used_bytes  = used_wide[USED_W-1:0];

endmodule

/* rtl/core/lrbd_checker.sv */
// Port-level checks for line_ring_buffer_drain_core, attached by bind.
// Depends on lrbd_pkg.
module lrbd_checker
    import lrbd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input cmd_word_t cmd,
    input logic      done,
    input rsp_word_t rsp
);

    // A result never shows while a drain scan is running
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Every non-drain command answers in the next cycle
    a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.mode != MODE_DRAIN) |=> done)
        else $error("missing result after push or pull");

    // A result follows a taken command or the end of a scan
    a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result without a command");

    // Ring occupancy only moves when a command is taken
    a_used_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> $stable(rsp.used_bytes))
        else $error("used bytes changed without a command");

endmodule

bind line_ring_buffer_drain_core lrbd_checker u_lrbd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
);
